/* hw/rtl/wtei_pkg.sv */
package wtei_pkg;

    localparam int TIME_W    = 40;
    localparam int PWR_W     = 24;
    localparam int ENERGY_W  = 64;
    localparam int PTS_W     = 20;
    localparam int STAT_W    = 3;
    localparam int MUL_STEPS = 24;
    localparam int CNT_W     = 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic REG_WINDOW_START = 1'b0;
    localparam logic REG_WINDOW_END   = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FEW     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_MANY    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NEG     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_MONO    = 3'd4;
    localparam logic [STAT_W-1:0] STAT_WINDOW  = 3'd5;
    localparam logic [STAT_W-1:0] STAT_BRACKET = 3'd6;

    localparam logic [PTS_W-1:0]    PTS_MAX    = '1;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic [PWR_W-1:0]  p;
        logic              last;
        logic              neg;
        logic              nonmono;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0] start_us;
        logic [TIME_W-1:0] end_us;
    } window_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [PTS_W-1:0]    points;
        logic [TIME_W-1:0]   gap;
        logic [ENERGY_W-1:0] energy;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ENDCHK,
        ST_APSET,
        ST_MUL,
        ST_DIV,
        ST_ACC1,
        ST_ACC2,
        ST_DONE
    } state_t;

endpackage

/* hw/rtl/wtei_front.sv */
module wtei_front
    import wtei_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // sample_time[39:0], sample_power[63:40]
    input  logic         s_tlast,   // last_sample
    output logic         push_valid,
    input  logic         push_ready,
    output item_t        push_item
);

    logic [TIME_W-1:0] prev_time_reg, prev_time_next;
    logic              have_prev_reg, have_prev_next;
    logic              accept;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;

    always_comb begin
        push_item.t       = s_tdata[TIME_W-1:0];
        push_item.p       = s_tdata[TIME_W+PWR_W-1:TIME_W];
        push_item.last    = s_tlast;
        push_item.neg     = s_tdata[TIME_W+PWR_W-1];
        push_item.nonmono = have_prev_reg && (s_tdata[TIME_W-1:0] <= prev_time_reg);
    end

    always_comb begin
        prev_time_next = prev_time_reg;
        have_prev_next = have_prev_reg;
        if (accept) begin
            prev_time_next = s_tdata[TIME_W-1:0];
            have_prev_next = !s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
        end else begin
            have_prev_reg <= have_prev_next;
        end
        prev_time_reg <= prev_time_next;
    end

endmodule

/* hw/rtl/wtei_queue.sv */
module wtei_queue
    import wtei_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hw/rtl/wtei_back.sv */
module wtei_back
    import wtei_pkg::*;
#(
    parameter int MAX_SAMPLES = 1000000
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  window_t      win,
    input  logic         pop_valid,
    output logic         pop_ready,
    input  item_t        pop_item,
    output logic         m_tvalid,
    input  logic         m_tready,
    output result_t      m_result
);

    localparam int TC_W = $clog2(MAX_SAMPLES + 2);
    localparam logic [TC_W-1:0] TC_TOP  = TC_W'(MAX_SAMPLES + 1);
    localparam logic [TC_W-1:0] TC_MANY = TC_W'(MAX_SAMPLES);
    localparam logic [TC_W-1:0] TC_TWO  = TC_W'(2);

    state_t              state_reg, state_next;
    item_t               item_reg, item_next;
    logic [TIME_W-1:0]   prev_time_reg, prev_time_next;
    logic [PWR_W-1:0]    prev_power_reg, prev_power_next;
    logic                have_prev_reg, have_prev_next;
    logic [TC_W-1:0]     tc_reg, tc_next;
    logic [PTS_W-1:0]    pc_reg, pc_next;
    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic                half_reg, half_next;
    logic                sat_reg, sat_next;
    logic [TIME_W-1:0]   gap_reg, gap_next;
    logic                sb_reg, sb_next;
    logic                er_reg, er_next;
    logic [TIME_W-1:0]   clip_time_reg, clip_time_next;
    logic [PWR_W-1:0]    clip_power_reg, clip_power_next;
    logic [STAT_W-1:0]   err_reg, err_next;
    logic                interp_end_reg, interp_end_next;
    logic                mul_interp_reg, mul_interp_next;
    logic [TIME_W-1:0]   ap_x_reg, ap_x_next;
    logic [PWR_W-1:0]    ap_q_reg, ap_q_next;
    logic                ap_end_reg, ap_end_next;
    logic [PWR_W-1:0]    ma_reg, ma_next;
    logic [PWR_W-1:0]    mb_reg, mb_next;
    logic [63:0]         a_reg, a_next;
    logic [63:0]         b_reg, b_next;
    logic [63:0]         acc_reg, acc_next;
    logic [TIME_W-1:0]   d_reg, d_next;
    logic [TIME_W-1:0]   rem_reg, rem_next;
    logic [PWR_W-1:0]    dl_reg, dl_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic [TC_W-1:0]     tc_inc;
    logic [STAT_W-1:0]   err_new;
    logic                win_ok, run, hit, eq_s, ix_deg, direct_end;
    logic [TIME_W-1:0]   ix_x, ix_xc, ix_a, ix_b, ix_d, ap_dt;
    logic [63:0]         mul_add;
    logic [TIME_W:0]     div_rem2;
    logic                div_ge;
    logic [TIME_W-1:0]   div_rem;
    logic [PWR_W-1:0]    div_q;
    logic [ENERGY_W:0]   acc_sum;
    logic                out_load, done_go;
    logic [STAT_W-1:0]   status_w;

    assign pop_ready = state_reg == ST_IDLE;
    assign m_tvalid  = out_valid_reg;
    assign m_result  = out_reg;

    assign tc_inc  = (tc_reg < TC_TOP) ? tc_reg + 1'b1 : tc_reg;
    assign err_new = (err_reg != STAT_OK) ? err_reg :
                     item_reg.neg ? STAT_NEG :
                     item_reg.nonmono ? STAT_MONO : STAT_OK;
    assign win_ok  = win.start_us < win.end_us;
    assign run     = (err_new == STAT_OK) && win_ok;
    assign eq_s    = item_reg.t == win.start_us;
    assign hit     = have_prev_reg ? (prev_time_reg < win.start_us && item_reg.t >= win.start_us)
                                   : eq_s;

    assign ix_x   = (state_reg == ST_EVAL) ? win.start_us : win.end_us;
    assign ix_xc  = (ix_x < prev_time_reg) ? prev_time_reg :
                    (ix_x > item_reg.t) ? item_reg.t : ix_x;
    assign ix_a   = item_reg.t - ix_xc;
    assign ix_b   = ix_xc - prev_time_reg;
    assign ix_d   = item_reg.t - prev_time_reg;
    assign ix_deg = item_reg.t <= prev_time_reg;
    assign direct_end = (item_reg.t == win.end_us) || !have_prev_reg || ix_deg;

    assign ap_dt = (ap_x_reg >= clip_time_reg) ? ap_x_reg - clip_time_reg : '0;

    assign mul_add = acc_reg + (ma_reg[0] ? a_reg : 64'd0) + (mb_reg[0] ? b_reg : 64'd0);

    assign div_rem2 = {rem_reg, dl_reg[PWR_W-1]};
    assign div_ge   = div_rem2 >= {1'b0, d_reg};
    assign div_rem  = div_ge ? TIME_W'(div_rem2 - {1'b0, d_reg}) : div_rem2[TIME_W-1:0];
    assign div_q    = {dl_reg[PWR_W-2:0], div_ge};

    assign acc_sum = {1'b0, energy_reg} + {2'b00, acc_reg[63:1]};

    assign out_load = (state_reg == ST_DONE) && item_reg.last && (!out_valid_reg || m_tready);
    assign done_go  = !item_reg.last || out_load;

    always_comb begin
        if (tc_reg < TC_TWO) begin
            status_w = STAT_FEW;
        end else if (tc_reg > TC_MANY) begin
            status_w = STAT_MANY;
        end else if (err_reg != STAT_OK) begin
            status_w = err_reg;
        end else if (!win_ok) begin
            status_w = STAT_WINDOW;
        end else if (!(sb_reg && er_reg)) begin
            status_w = STAT_BRACKET;
        end else begin
            status_w = STAT_OK;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (!run) begin
                    state_next = ST_DONE;
                end else if (sb_reg) begin
                    state_next = ST_ENDCHK;
                end else if (!hit) begin
                    state_next = ST_DONE;
                end else if (eq_s || ix_deg) begin
                    state_next = ST_ENDCHK;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_ENDCHK: begin
                if (er_reg) begin
                    state_next = ST_DONE;
                end else if (item_reg.t < win.end_us) begin
                    state_next = (item_reg.t > clip_time_reg) ? ST_APSET : ST_DONE;
                end else begin
                    state_next = direct_end ? ST_APSET : ST_MUL;
                end
            end
            ST_APSET: state_next = ST_MUL;
            ST_MUL: begin
                if (cnt_reg == '0) state_next = mul_interp_reg ? ST_DIV : ST_ACC1;
            end
            ST_DIV: begin
                if (cnt_reg == '0) state_next = interp_end_reg ? ST_APSET : ST_ENDCHK;
            end
            ST_ACC1: state_next = ST_ACC2;
            ST_ACC2: state_next = ST_DONE;
            ST_DONE: begin
                if (done_go) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        item_next       = item_reg;
        prev_time_next  = prev_time_reg;
        prev_power_next = prev_power_reg;
        have_prev_next  = have_prev_reg;
        tc_next         = tc_reg;
        pc_next         = pc_reg;
        energy_next     = energy_reg;
        half_next       = half_reg;
        sat_next        = sat_reg;
        gap_next        = gap_reg;
        sb_next         = sb_reg;
        er_next         = er_reg;
        clip_time_next  = clip_time_reg;
        clip_power_next = clip_power_reg;
        err_next        = err_reg;
        interp_end_next = interp_end_reg;
        mul_interp_next = mul_interp_reg;
        ap_x_next       = ap_x_reg;
        ap_q_next       = ap_q_reg;
        ap_end_next     = ap_end_reg;
        ma_next         = ma_reg;
        mb_next         = mb_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        acc_next        = acc_reg;
        d_next          = d_reg;
        rem_next        = rem_reg;
        dl_next         = dl_reg;
        cnt_next        = cnt_reg;
        out_next        = out_reg;
        out_valid_next  = (out_valid_reg && m_tready) ? 1'b0 : out_valid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) item_next = pop_item;
            end
            ST_EVAL: begin
                tc_next  = tc_inc;
                err_next = err_new;
                if (run && !sb_reg && hit) begin
                    clip_time_next = win.start_us;
                    if (eq_s || ix_deg) begin
                        clip_power_next = item_reg.p;
                        sb_next         = 1'b1;
                        pc_next         = PTS_W'(1);
                    end else begin
                        ma_next         = prev_power_reg;
                        mb_next         = item_reg.p;
                        a_next          = 64'(ix_a);
                        b_next          = 64'(ix_b);
                        acc_next        = '0;
                        d_next          = ix_d;
                        cnt_next        = CNT_W'(MUL_STEPS - 1);
                        mul_interp_next = 1'b1;
                        interp_end_next = 1'b0;
                    end
                end
            end
            ST_ENDCHK: begin
                if (!er_reg) begin
                    if (item_reg.t < win.end_us) begin
                        ap_x_next   = item_reg.t;
                        ap_q_next   = item_reg.p;
                        ap_end_next = 1'b0;
                    end else if (direct_end) begin
                        ap_x_next   = win.end_us;
                        ap_q_next   = item_reg.p;
                        ap_end_next = 1'b1;
                    end else begin
                        ma_next         = prev_power_reg;
                        mb_next         = item_reg.p;
                        a_next          = 64'(ix_a);
                        b_next          = 64'(ix_b);
                        acc_next        = '0;
                        d_next          = ix_d;
                        cnt_next        = CNT_W'(MUL_STEPS - 1);
                        mul_interp_next = 1'b1;
                        interp_end_next = 1'b1;
                    end
                end
            end
            ST_APSET: begin
                if (ap_dt > gap_reg) gap_next = ap_dt;
                ma_next         = clip_power_reg + ap_q_reg;
                mb_next         = '0;
                a_next          = 64'(ap_dt);
                b_next          = '0;
                acc_next        = '0;
                cnt_next        = CNT_W'(MUL_STEPS - 1);
                mul_interp_next = 1'b0;
            end
            ST_MUL: begin
                acc_next = mul_add;
                ma_next  = ma_reg >> 1;
                mb_next  = mb_reg >> 1;
                a_next   = a_reg << 1;
                b_next   = b_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    rem_next = mul_add[63:PWR_W];
                    dl_next  = mul_add[PWR_W-1:0];
                    cnt_next = CNT_W'(MUL_STEPS - 1);
                end
            end
            ST_DIV: begin
                rem_next = div_rem;
                dl_next  = div_q;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    if (interp_end_reg) begin
                        ap_x_next   = win.end_us;
                        ap_q_next   = div_q;
                        ap_end_next = 1'b1;
                    end else begin
                        clip_power_next = div_q;
                        sb_next         = 1'b1;
                        pc_next         = PTS_W'(1);
                    end
                end
            end
            ST_ACC1: begin
                if (!sat_reg) begin
                    if (acc_sum[ENERGY_W]) begin
                        energy_next = ENERGY_MAX;
                        sat_next    = 1'b1;
                    end else begin
                        energy_next = acc_sum[ENERGY_W-1:0];
                    end
                end
            end
            ST_ACC2: begin
                if (half_reg && acc_reg[0]) begin
                    half_next = 1'b0;
                    if (energy_reg == ENERGY_MAX) begin
                        sat_next = 1'b1;
                    end else begin
                        energy_next = energy_reg + 1'b1;
                    end
                end else begin
                    half_next = half_reg | acc_reg[0];
                end
                if (pc_reg != PTS_MAX) pc_next = pc_reg + 1'b1;
                clip_time_next  = ap_x_reg;
                clip_power_next = ap_q_reg;
                if (ap_end_reg) er_next = 1'b1;
            end
            ST_DONE: begin
                prev_time_next  = item_reg.t;
                prev_power_next = item_reg.p;
                have_prev_next  = 1'b1;
                if (out_load) begin
                    out_valid_next  = 1'b1;
                    out_next.status = status_w;
                    out_next.energy = (status_w == STAT_OK) ? energy_reg : '0;
                    out_next.gap    = (status_w == STAT_OK) ? gap_reg : '0;
                    out_next.points = (status_w == STAT_OK) ? pc_reg : '0;
                    have_prev_next  = 1'b0;
                    tc_next         = '0;
                    pc_next         = '0;
                    energy_next     = '0;
                    half_next       = 1'b0;
                    sat_next        = 1'b0;
                    gap_next        = '0;
                    sb_next         = 1'b0;
                    er_next         = 1'b0;
                    clip_time_next  = '0;
                    clip_power_next = '0;
                    err_next        = STAT_OK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            tc_reg        <= '0;
            pc_reg        <= '0;
            energy_reg    <= '0;
            half_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            gap_reg       <= '0;
            sb_reg        <= 1'b0;
            er_reg        <= 1'b0;
            err_reg       <= STAT_OK;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            tc_reg        <= tc_next;
            pc_reg        <= pc_next;
            energy_reg    <= energy_next;
            half_reg      <= half_next;
            sat_reg       <= sat_next;
            gap_reg       <= gap_next;
            sb_reg        <= sb_next;
            er_reg        <= er_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
        item_reg       <= item_next;
        prev_time_reg  <= prev_time_next;
        prev_power_reg <= prev_power_next;
        clip_time_reg  <= clip_time_next;
        clip_power_reg <= clip_power_next;
        interp_end_reg <= interp_end_next;
        mul_interp_reg <= mul_interp_next;
        ap_x_reg       <= ap_x_next;
        ap_q_reg       <= ap_q_next;
        ap_end_reg     <= ap_end_next;
        ma_reg         <= ma_next;
        mb_reg         <= mb_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        acc_reg        <= acc_next;
        d_reg          <= d_next;
        rem_reg        <= rem_next;
        dl_reg         <= dl_next;
        cnt_reg        <= cnt_next;
        out_reg        <= out_next;
    end

    a_div_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < d_reg))
        else $error("divider remainder not below divisor");

    a_end_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        er_reg |-> sb_reg)
        else $error("window end reached before start was bracketed");

    a_clip_power_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        (sb_reg && state_reg != ST_EVAL) |-> !clip_power_reg[PWR_W-1])
        else $error("clipped power went negative");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE && item_reg.last))
        else $error("result issued without a last sample");

endmodule

/* hw/rtl/windowed_trapezoid_energy_integrator.sv */
// Trapezoid-rule energy integrator over a configured time window. Each input
// transaction is one sample (time in us, power in mW); the sample with tlast
// closes the trace and yields one result transaction with energy in nJ, the
// largest gap, the clipped point count and a status. A four-entry queue sits
// between the input side and the sequencer. In the sequencer a sample that adds
// a segment passes through the 24-step shift-add multiplier; each window edge
// a sample crosses adds the 24-step multiply and 24-step restoring divide of
// the edge interpolation. A last sample also waits while the previous result
// is still held. The user must write the window registers through
// cfg_wr_en/cfg_index/cfg_wdata only while the block is idle; the block itself
// does not enforce this.
module windowed_trapezoid_energy_integrator
    import wtei_pkg::*;
#(
    parameter int MAX_SAMPLES = 1000000
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [39:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // sample_time[39:0], sample_power[63:40]
    input  logic         s_tlast,   // last_sample
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // energy_nanojoules[63:0], max_gap_us[103:64],
                                    // window_points[123:104], status[126:124]
);

    window_t win_reg, win_next;
    logic    push_valid, push_ready, pop_valid, pop_ready;
    item_t   push_item, pop_item;
    result_t result;

    always_comb begin
        win_next = win_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_WINDOW_START: win_next.start_us = cfg_wdata;
                REG_WINDOW_END:   win_next.end_us   = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else begin
            win_reg <= win_next;
        end
    end

    wtei_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    wtei_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    wtei_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .win       (win_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (result)
    );

    assign m_tdata = {1'b0, result};

endmodule
